### design/piecewise_linear_temp_calibration_core_defines.svh
// assertion macros for the temperature calibration core
`ifndef PIECEWISE_LINEAR_TEMP_CALIBRATION_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_TEMP_CALIBRATION_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on clk, disabled in reset
`define PLTC_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("pltc: same-cycle check failed");
// next-cycle implication, checked on clk, disabled in reset
`define PLTC_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("pltc: next-cycle check failed");
`else
`define PLTC_ASSERT_NOW(lbl, ant, con)
`define PLTC_ASSERT_NEXT(lbl, ant, con)
`endif

`endif

### design/pltc_pkg.sv
// types and constants shared by the temperature calibration core
`timescale 1ns / 1ps

package pltc_pkg;

  // command codes of the input item
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  // limits and reference grid, hundredths of a degree
  localparam int LOW_LIMIT      = -8000;
  localparam int HIGH_LIMIT     = 15000;
  localparam int REF_START_HUND = -4000;
  localparam int REF_STEP_HUND  = 1000;
  localparam int INNER_DY       = 1000;
  localparam int LOW_DY         = 4000;
  // reset contents of the point table, tenths of a degree
  localparam int REF_START_TENTHS = -400;
  localparam int REF_STEP_TENTHS  = 100;

  // datapath widths
  localparam int V_W    = 21;   // scaled points, input and their differences, signed
  localparam int DEN_W  = 20;   // segment width, positive
  localparam int DX_W   = 19;   // offset into the segment, non-negative
  localparam int DY_W   = 15;   // magnitude of the reference span
  localparam int MAG_W  = DY_W + DX_W;
  localparam int NUM_W  = MAG_W + 2;
  localparam int D_W    = DEN_W + 1;
  localparam int Q_W    = 16;
  localparam int DCNT_W = $clog2(Q_W);
  localparam int Y_W    = 17;
  localparam int RES_W  = 18;

  typedef enum logic [2:0] {
    ST_INNER = 3'd0,
    ST_LOW   = 3'd1,
    ST_HIGH  = 3'd2,
    ST_CLAMP = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_SCAN,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        point_index;
    logic signed [15:0] point_value;
    logic signed [15:0] temperature_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_out;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic write_pt;
    logic load_x;
    logic classify;
    logic scan_step;
    logic mul;
    logic prep;
    logic div_step;
    logic load_out;
  } pltc_cmd_t;

  typedef struct packed {
    logic cls_settled;
    logic cls_inner;
    logic scan_hit;
  } pltc_sts_t;

  // stored point (tenths) to hundredths
  function automatic logic signed [V_W-1:0] scale10(input logic signed [15:0] v);
    logic signed [V_W-1:0] e;
    e = V_W'(v);
    return (e <<< 3) + (e <<< 1);
  endfunction

endpackage

### design/pltc_ctrl.sv
// sequencing state machine of the temperature calibration core
`timescale 1ns / 1ps
`include "piecewise_linear_temp_calibration_core_defines.svh"

module pltc_ctrl
  import pltc_pkg::*;
#(
  parameter int NUM_POINTS = 14,
  parameter int IDX_W      = $clog2(NUM_POINTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pltc_sts_t        sts,
  output pltc_cmd_t        cmd,
  output logic [IDX_W-1:0] scan_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(Q_W - 1);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [DCNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    div_cnt_nxt  = div_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_cmd == CMD_CORRECT) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        scan_idx_nxt = IDX_W'(1);
        priority if (sts.cls_settled) state_nxt = S_FIN;
        else if (sts.cls_inner) state_nxt = S_SCAN;
        else state_nxt = S_MUL;
      end
      S_SCAN: begin
        priority if (sts.scan_hit) state_nxt = S_MUL;
        else if (scan_idx_r == LAST_IDX) state_nxt = S_FIN;
        else scan_idx_nxt = scan_idx_r + IDX_W'(1);
      end
      S_MUL: state_nxt = S_PREP;
      S_PREP: begin
        state_nxt   = S_DIV;
        div_cnt_nxt = '0;
      end
      S_DIV: begin
        if (div_cnt_r == DIV_LAST) state_nxt = S_FIN;
        else div_cnt_nxt = div_cnt_r + DCNT_W'(1);
      end
      S_FIN: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.write_pt = in_valid && in_cmd == CMD_WRITE;
        cmd.load_x   = in_valid && in_cmd == CMD_CORRECT;
      end
      S_CLASS: cmd.classify  = 1'b1;
      S_SCAN:  cmd.scan_step = 1'b1;
      S_MUL:   cmd.mul       = 1'b1;
      S_PREP:  cmd.prep      = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_FIN:   cmd.load_out  = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_idx_r  <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign scan_idx  = scan_idx_r;

  `PLTC_ASSERT_NEXT(a_correct_starts, in_valid && in_ready && in_cmd == CMD_CORRECT, state_r == S_CLASS)
  `PLTC_ASSERT_NEXT(a_div_runs, state_r == S_DIV && div_cnt_r != DIV_LAST, state_r == S_DIV)
  `PLTC_ASSERT_NEXT(a_fin_delivers, state_r == S_FIN && slot_free, state_r == S_IDLE && out_valid_r)
  `PLTC_ASSERT_NEXT(a_scan_ends, state_r == S_SCAN && !sts.scan_hit && scan_idx_r == LAST_IDX, state_r == S_FIN)
  `PLTC_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd))

endmodule

### design/pltc_dp.sv
// point table, segment search, multiplier and serial divider
`timescale 1ns / 1ps

module pltc_dp
  import pltc_pkg::*;
#(
  parameter int NUM_POINTS = 14,
  parameter int IDX_W      = $clog2(NUM_POINTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_item,
  input  pltc_cmd_t        cmd,
  input  logic [IDX_W-1:0] scan_idx,
  output pltc_sts_t        sts,
  output out_item_t        out_item
);

  localparam int REF_LAST   = REF_START_HUND + REF_STEP_HUND * (NUM_POINTS - 1);
  localparam int HIGH_DY    = HIGH_LIMIT - REF_LAST;
  localparam int HIGH_DYMAG = (HIGH_DY < 0) ? -HIGH_DY : HIGH_DY;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

  logic signed [15:0]    pts_r [NUM_POINTS];
  logic signed [15:0]    x_r;
  logic signed [V_W-1:0] xv, p0, pl, cur;
  logic signed [V_W-1:0] den_low, den_high, den_in, dx;
  logic                  clamp_lo, clamp_hi, is_low, is_high, low_ok, high_ok;

  logic signed [V_W-1:0] prev_r, a_r;
  logic [DEN_W-1:0]      den_r;
  logic signed [Y_W-1:0] y0_r, ref_r;
  logic [DY_W-1:0]       dy_mag_r;
  logic                  dy_neg_r;
  status_t               status_r;
  logic signed [RES_W-1:0] res_r, res_q, res_fin;
  logic [MAG_W-1:0]      prod_r;
  logic [NUM_W-1:0]      num;
  logic [D_W-1:0]        rem_r, dsr_r;
  logic [Q_W-1:0]        nlo_r;
  logic [D_W:0]          rem_sh;
  logic                  ge;
  out_item_t             out_r;

  // calibration point table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        pts_r[k] <= 16'(REF_START_TENTHS + REF_STEP_TENTHS * k);
      end
    end else if (cmd.write_pt) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        if (int'(in_item.point_index) == k) pts_r[k] <= in_item.point_value;
      end
    end
  end

  assign xv  = V_W'(x_r);
  assign p0  = scale10(pts_r[0]);
  assign pl  = scale10(pts_r[NUM_POINTS-1]);
  assign cur = scale10(pts_r[scan_idx]);

  assign clamp_lo = xv <= V_W'(LOW_LIMIT);
  assign clamp_hi = xv >= V_W'(HIGH_LIMIT);
  assign is_low   = xv <= p0;
  assign is_high  = xv >= pl;
  assign den_low  = p0 - V_W'(LOW_LIMIT);
  assign den_high = V_W'(HIGH_LIMIT) - pl;
  assign den_in   = cur - prev_r;
  assign low_ok   = !den_low[V_W-1] && (den_low != '0);
  assign high_ok  = !den_high[V_W-1] && (den_high != '0);

  assign sts.cls_settled = clamp_lo || clamp_hi || (is_low && !low_ok) ||
                           (!is_low && is_high && !high_ok);
  assign sts.cls_inner   = !clamp_lo && !clamp_hi && !is_low && !is_high;
  assign sts.scan_hit    = (xv >= prev_r) && (xv < cur);

  assign dx = xv - a_r;

  // segment selection
  always_ff @(posedge clk) begin
    if (cmd.load_x) x_r <= in_item.temperature_in;
    if (cmd.classify) begin
      res_r  <= clamp_lo ? RES_W'(LOW_LIMIT) : clamp_hi ? RES_W'(HIGH_LIMIT) : RES_W'(x_r);
      prev_r <= p0;
      ref_r  <= Y_W'(REF_START_HUND);
      priority if (clamp_lo) begin
        status_r <= ST_CLAMP;
      end else if (clamp_hi) begin
        status_r <= ST_CLAMP;
      end else if (is_low) begin
        status_r <= low_ok ? ST_LOW : ST_NONE;
        y0_r     <= Y_W'(LOW_LIMIT);
        a_r      <= V_W'(LOW_LIMIT);
        den_r    <= den_low[DEN_W-1:0];
        dy_mag_r <= DY_W'(LOW_DY);
        dy_neg_r <= 1'b0;
      end else if (is_high) begin
        status_r <= high_ok ? ST_HIGH : ST_NONE;
        y0_r     <= Y_W'(REF_LAST);
        a_r      <= pl;
        den_r    <= den_high[DEN_W-1:0];
        dy_mag_r <= DY_W'(HIGH_DYMAG);
        dy_neg_r <= (HIGH_DY < 0);
      end else begin
        status_r <= ST_NONE;
      end
    end
    if (cmd.scan_step) begin
      if (sts.scan_hit) begin
        status_r <= ST_INNER;
        y0_r     <= ref_r;
        a_r      <= prev_r;
        den_r    <= den_in[DEN_W-1:0];
        dy_mag_r <= DY_W'(INNER_DY);
        dy_neg_r <= 1'b0;
      end else begin
        prev_r <= cur;
        ref_r  <= ref_r + Y_W'(REF_STEP_HUND);
        // running off the table: no enclosing segment
        if (scan_idx == LAST_IDX) status_r <= ST_NONE;
      end
    end
  end

  // |dy| * dx, then rounded quotient (2*mag + den) / (2*den)
  assign num    = NUM_W'({prod_r, 1'b0}) + NUM_W'(den_r);
  assign rem_sh = {rem_r, nlo_r[Q_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= MAG_W'(dy_mag_r) * MAG_W'(dx[DX_W-1:0]);
    if (cmd.prep) begin
      // quotient fits in Q_W bits, so the top part already sits below the divisor
      rem_r <= D_W'(num[NUM_W-1:Q_W]);
      nlo_r <= num[Q_W-1:0];
      dsr_r <= {den_r, 1'b0};
    end
    if (cmd.div_step) begin
      rem_r <= ge ? D_W'(rem_sh - {1'b0, dsr_r}) : D_W'(rem_sh);
      nlo_r <= {nlo_r[Q_W-2:0], ge};
    end
  end

  assign res_q = dy_neg_r ? RES_W'(y0_r) - RES_W'({1'b0, nlo_r})
                          : RES_W'(y0_r) + RES_W'({1'b0, nlo_r});

  always_comb begin
    if (status_r == ST_INNER || status_r == ST_LOW || status_r == ST_HIGH) res_fin = res_q;
    else res_fin = res_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      priority if (res_fin > RES_W'(32767)) out_r.temperature_out <= 16'sd32767;
      else if (res_fin < -RES_W'(32768)) out_r.temperature_out <= -16'sd32768;
      else out_r.temperature_out <= res_fin[15:0];
      out_r.status <= status_r;
    end
  end

  assign out_item = out_r;

endmodule

### design/piecewise_linear_temp_calibration_core.sv
// Piecewise-linear temperature calibration core. A write item (cmd 0) with an index below
// NUM_POINTS replaces that stored calibration point in the cycle it is accepted; write items
// return nothing and are taken back to back. A correct item (cmd 1) returns one result: the
// input clamped to -80.00..150.00 C and mapped linearly through the enclosing segment, or
// extrapolated at the ends; an input with no enclosing inner segment, or in an end segment
// that is empty or reversed, comes out unchanged. After a correct item is accepted the core
// classifies it; clamped inputs and empty or reversed end segments go straight to the output
// load. An inner input is searched segment by segment, one stored point per cycle, until the
// enclosing segment is found or the table runs out; an inner segment found, or an end segment,
// then passes through the multiplier, a divider set-up step and the 16-step restoring divider
// that forms the rounded quotient before the output load. The load waits while the output
// register still holds an untaken result; the next item can be taken in the cycle after the
// load. The output register lets the next item enter while a result still waits to be taken.
`timescale 1ns / 1ps

module piecewise_linear_temp_calibration_core
  import pltc_pkg::*;
#(
  parameter int NUM_POINTS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(NUM_POINTS);

  pltc_cmd_t        cmd;
  pltc_sts_t        sts;
  logic [IDX_W-1:0] scan_idx;

  pltc_ctrl #(
    .NUM_POINTS(NUM_POINTS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_item.cmd),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  pltc_dp #(
    .NUM_POINTS(NUM_POINTS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .scan_idx(scan_idx),
    .sts     (sts),
    .out_item(out_item)
  );

endmodule

### tb/pltc_correction_checker.sv
// checker for the calibration core: tracks the point table, predicts corrections, compares
`timescale 1ns / 1ps

module pltc_correction_checker
  import pltc_pkg::*;
#(
  parameter int NUM_POINTS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_results
);

  logic signed [15:0] cal_table [NUM_POINTS];
  out_item_t          expected_corrections [$];
  out_item_t          want;

  initial fail_count = 0;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] pltc mismatch: %s", $time, what);
  endtask

  // y0 + dy*dx/den, halves away from zero
  function automatic longint round_ratio(input longint y0, input longint dy,
                                         input longint dx, input longint den);
    longint num;
    longint mag;
    longint q;
    num = dy * dx;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    return (num < 0) ? y0 - q : y0 + q;
  endfunction

  function automatic longint ref_hund(input int i);
    return longint'(REF_START_HUND + REF_STEP_HUND * i);
  endfunction

  function automatic out_item_t correct_temperature(input logic signed [15:0] t_in);
    longint    x;
    longint    res;
    longint    p0;
    longint    pl;
    longint    a;
    longint    b;
    status_t   st;
    out_item_t r;
    int        last;
    last = NUM_POINTS - 1;
    x    = t_in;
    if (x <= LOW_LIMIT) begin
      res = LOW_LIMIT;
      st  = ST_CLAMP;
    end else if (x >= HIGH_LIMIT) begin
      res = HIGH_LIMIT;
      st  = ST_CLAMP;
    end else begin
      p0  = 10 * longint'(cal_table[0]);
      pl  = 10 * longint'(cal_table[last]);
      res = x;
      st  = ST_NONE;
      if (x <= p0) begin
        if (p0 - LOW_LIMIT > 0) begin
          res = round_ratio(LOW_LIMIT, ref_hund(0) - LOW_LIMIT, x - LOW_LIMIT, p0 - LOW_LIMIT);
          st  = ST_LOW;
        end
      end else if (x >= pl) begin
        if (HIGH_LIMIT - pl > 0) begin
          res = round_ratio(ref_hund(last), HIGH_LIMIT - ref_hund(last), x - pl,
                            HIGH_LIMIT - pl);
          st  = ST_HIGH;
        end
      end else begin
        // first enclosing segment wins, zero-width ones never enclose
        for (int i = 0; i < last && st == ST_NONE; i++) begin
          a = 10 * longint'(cal_table[i]);
          b = 10 * longint'(cal_table[i + 1]);
          if (x >= a && x < b) begin
            res = round_ratio(ref_hund(i), ref_hund(i + 1) - ref_hund(i), x - a, b - a);
            st  = ST_INNER;
          end
        end
      end
    end
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    r.temperature_out = res[15:0];
    r.status          = st;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        cal_table[i] = 16'(REF_START_TENTHS + REF_STEP_TENTHS * i);
      end
      expected_corrections.delete();
      pending_results <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_corrections.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no correction pending",
                                    out_item.temperature_out, out_item.status));
        end else begin
          want = expected_corrections.pop_front();
          if (out_item.temperature_out !== want.temperature_out) begin
            report_mismatch($sformatf("temperature_out %0d, predicted %0d",
                                      out_item.temperature_out, want.temperature_out));
          end
          if (out_item.status !== want.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      out_item.status, want.status));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_item.cmd == CMD_WRITE) begin
          if (in_item.point_index < NUM_POINTS) begin
            cal_table[in_item.point_index] = in_item.point_value;
          end
        end else begin
          expected_corrections.push_back(correct_temperature(in_item.temperature_in));
        end
      end
      pending_results <= expected_corrections.size();
    end
  end

endmodule

### tb/piecewise_linear_temp_calibration_core_tb.sv
// testbench top for the calibration core: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module piecewise_linear_temp_calibration_core_tb;
  import pltc_pkg::*;

  localparam int NUM_POINTS   = 14;
  localparam int TOTAL_ITEMS  = 1600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int fail_count;
  int pending_results;
  int cycle_count   = 0;
  int results_taken = 0;
  int items_sent    = 0;
  bit gaps_on       = 1'b1;

  // what the table holds, used only to aim temperatures at segments
  logic signed [15:0] shadow_pts [NUM_POINTS];

  always #2 clk = ~clk;

  piecewise_linear_temp_calibration_core #(.NUM_POINTS(NUM_POINTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  pltc_correction_checker #(.NUM_POINTS(NUM_POINTS)) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) results_taken <= results_taken + 1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] fit16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic in_item_t correct_item(input logic signed [15:0] t);
    in_item_t it;
    it.cmd            = CMD_CORRECT;
    it.point_index    = 4'($urandom);
    it.point_value    = 16'($urandom);
    it.temperature_in = t;
    return it;
  endfunction

  function automatic in_item_t write_item(input logic [3:0] idx, input logic signed [15:0] v);
    in_item_t it;
    it.cmd            = CMD_WRITE;
    it.point_index    = idx;
    it.point_value    = v;
    it.temperature_in = 16'($urandom);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.cmd == CMD_WRITE && it.point_index < NUM_POINTS) begin
      shadow_pts[it.point_index] = it.point_value;
    end
    items_sent++;
  endtask

  function automatic logic signed [15:0] pick_temperature();
    int r;
    int seg;
    int lo;
    int hi;
    int t;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      seg = $urandom_range(0, NUM_POINTS - 2);
      lo  = 10 * shadow_pts[seg];
      hi  = 10 * shadow_pts[seg + 1];
      if (hi < lo) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      return fit16(lo - 20 + int'($urandom_range(0, hi - lo + 40)));
    end else if (r < 60) begin
      // right on a point or one off either side
      seg = $urandom_range(0, NUM_POINTS - 1);
      return fit16(10 * shadow_pts[seg] + int'($urandom_range(0, 2)) - 1);
    end else if (r < 75) begin
      return 16'(int'($urandom_range(0, 23000)) - 8000);
    end else if (r < 85) begin
      return 16'($urandom);
    end
    t = ($urandom_range(0, 1) == 0) ? LOW_LIMIT : HIGH_LIMIT;
    return 16'(t + int'($urandom_range(0, 4)) - 2);
  endfunction

  // writes a whole table of the given flavor, points in shuffled order
  task automatic load_table(input int kind);
    int                 vals [NUM_POINTS];
    int                 order [NUM_POINTS];
    int                 j;
    int                 t;
    for (int i = 0; i < NUM_POINTS; i++) begin
      order[i] = i;
      case (kind)
        0, 3: begin
          vals[i] = REF_START_TENTHS + REF_STEP_TENTHS * i + int'($urandom_range(0, 120)) - 60;
        end
        1, 2: begin
          vals[i] = (i == 0) ? -900 + int'($urandom_range(0, 600))
                             : vals[i - 1] + int'($urandom_range(1, 130));
        end
        default: begin
          vals[i] = int'(16'($urandom)) - ((int'(16'($urandom)) & 0) );
          vals[i] = $signed(16'($urandom));
        end
      endcase
    end
    if (kind == 2) begin
      // one zero-width segment
      j           = $urandom_range(0, NUM_POINTS - 2);
      vals[j + 1] = vals[j];
    end
    if (kind == 3) begin
      // one point thrown out of order
      vals[$urandom_range(0, NUM_POINTS - 1)] = int'($urandom_range(0, 2300)) - 800;
    end
    for (int i = NUM_POINTS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NUM_POINTS; i++) begin
      send_item(write_item(4'(order[i]), 16'(vals[order[i]])));
    end
  endtask

  // receiver: random stalls, bursts of ready, and one long hold-off
  initial begin
    int stall;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && results_taken >= 150) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int kind;
    int r;
    int n;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      shadow_pts[i] = 16'(REF_START_TENTHS + REF_STEP_TENTHS * i);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset table: clamps at both ends, end segments, inner segments
    send_item(correct_item(-16'sd32768));
    send_item(correct_item(16'sd32767));
    send_item(correct_item(16'(LOW_LIMIT)));
    send_item(correct_item(16'(HIGH_LIMIT)));
    send_item(correct_item(16'(LOW_LIMIT + 1)));
    send_item(correct_item(-16'sd4000));
    send_item(correct_item(-16'sd3999));
    send_item(correct_item(16'sd9000));
    send_item(correct_item(16'(HIGH_LIMIT - 1)));
    send_item(correct_item(16'sd8999));
    // indexes past the table are dropped
    send_item(write_item(4'd15, 16'sd32767));
    send_item(write_item(4'd14, -16'sd32768));
    send_item(correct_item(16'sd0));
    // wide first segment gives exact halves
    send_item(write_item(4'd1, -16'sd200));
    send_item(correct_item(-16'sd3999));
    send_item(correct_item(-16'sd3997));
    send_item(write_item(4'd0, -16'sd32768));
    send_item(correct_item(16'(LOW_LIMIT + 1)));
    send_item(write_item(4'd13, 16'sd32767));
    send_item(correct_item(16'(HIGH_LIMIT - 1)));
    // zero-width segment is skipped
    send_item(write_item(4'd5, 16'sd0));
    send_item(correct_item(16'sd0));
    // first point above every point but the last
    send_item(write_item(4'd0, 16'sd1500));
    send_item(correct_item(16'sd100));
    send_item(correct_item(-16'sd1));

    while (items_sent < TOTAL_ITEMS) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      r       = $urandom_range(0, 99);
      kind    = (r < 35) ? 0 : (r < 60) ? 1 : (r < 75) ? 2 : (r < 90) ? 3 : 4;
      load_table(kind);
      n = $urandom_range(30, 110);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 86) begin
          send_item(correct_item(pick_temperature()));
        end else if (r < 95) begin
          send_item(write_item(4'($urandom_range(0, NUM_POINTS - 1)),
                               16'(int'($urandom_range(0, 2300)) - 800)));
        end else begin
          send_item(write_item(4'($urandom_range(0, 15)), 16'($urandom)));
        end
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/pltc_pkg.sv
design/pltc_ctrl.sv
design/pltc_dp.sv
design/piecewise_linear_temp_calibration_core.sv
tb/pltc_correction_checker.sv
tb/piecewise_linear_temp_calibration_core_tb.sv
